@@ design/vertex_light_accumulator_macros.svh @@
// Assertion shorthands used by the checker of the light accumulator.
`ifndef VERTEX_LIGHT_ACCUMULATOR_MACROS_SVH
`define VERTEX_LIGHT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VLA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VLA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/vla_pkg.sv @@
package vla_pkg;

   localparam int NUM_LIGHTS = 8;
   localparam int FRAC_BITS  = 15;

   localparam int FUNC_W  = 2;
   localparam int SLOT_W  = 3;
   localparam int KIND_W  = 2;
   localparam int COLOR_W = 15;
   localparam int VEC_W   = 16;
   localparam int OUT_W   = 15;

   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_VERTEX = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_DIRECTIONAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_AMBIENT     = 2'd1;

   // Datapath widths: three-term dot product, intensity, per-slot contribution, sum
   localparam int PROD_W = 2 * VEC_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int INT_W  = (DOT_W - FRAC_BITS > FRAC_BITS + 1) ? DOT_W - FRAC_BITS
                                                              : FRAC_BITS + 1;
   localparam int MUL_W  = INT_W + COLOR_W;
   localparam int CON_W  = MUL_W - FRAC_BITS;
   localparam int ACC_W  = CON_W + $clog2(NUM_LIGHTS) + 1;
   localparam int SUM_W  = (ACC_W > FRAC_BITS + 1) ? ACC_W : FRAC_BITS + 1;

   // Shade pipeline: product, intensity, contribution, accumulate
   localparam int PIPE_LAT = 4;
   localparam int CNT_W    = $clog2(NUM_LIGHTS + PIPE_LAT);

   localparam logic [INT_W-1:0] ONE_INT = INT_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [KIND_W-1:0]           kind;
      logic [2:0][COLOR_W-1:0]     color;
      logic [2:0][VEC_W-1:0]       dir;
      logic [COLOR_W-1:0]          scale;
   } slot_type;

   typedef struct packed {
      logic shift;
      logic write;
      logic clear;
   } cell_ctl_type;

endpackage

@@ design/vla_cell.sv @@
module vla_cell import vla_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  slot_type     wr_data,
   input  logic         nb_valid,
   input  slot_type     nb_data,
   output logic         valid,
   output slot_type     data
);

   logic     valid_ff;
   slot_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.write) begin
         valid_ff <= 1'b1;
      end else if (ctl.shift) begin
         valid_ff <= nb_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         data_ff <= wr_data;
      end else if (ctl.shift) begin
         data_ff <= nb_data;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

@@ design/vla_shade.sv @@
module vla_shade import vla_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        issue,
   input  logic                        slot_valid,
   input  slot_type                    slot,
   input  logic [2:0][VEC_W-1:0]       normal,
   output logic [2:0][SUM_W-1:0]       sum
);

   // stage 1: normal times direction
   logic                          v1_ff;
   logic [2:0][PROD_W-1:0]        prod_ff, prod_in;
   logic [KIND_W-1:0]             kind1_ff;
   logic [COLOR_W-1:0]            scale1_ff;
   logic [2:0][COLOR_W-1:0]       color1_ff;
   // stage 2: intensity
   logic                          v2_ff;
   logic [INT_W-1:0]              inten_ff, inten_in;
   logic [2:0][COLOR_W-1:0]       color2_ff;
   // stage 3: contribution per channel
   logic                          v3_ff;
   logic [2:0][CON_W-1:0]         con_ff, con_in;
   // stage 4: running sums
   logic [2:0][SUM_W-1:0]         sum_ff;

   always_comb begin
      logic signed [PROD_W-1:0] a;
      logic signed [PROD_W-1:0] b;
      for (int c = 0; c < 3; c++) begin
         a = PROD_W'($signed(normal[c]));
         b = PROD_W'($signed(slot.dir[c]));
         prod_in[c] = a * b;
      end
   end

   always_comb begin
      logic signed [DOT_W-1:0] dot;
      logic signed [DOT_W-1:0] neg;
      logic signed [DOT_W-1:0] shifted;
      dot = DOT_W'($signed(prod_ff[0])) + DOT_W'($signed(prod_ff[1]))
          + DOT_W'($signed(prod_ff[2]));
      neg     = -dot;
      shifted = neg >>> FRAC_BITS;
      if (kind1_ff == KIND_DIRECTIONAL) begin
         inten_in = (neg > 0) ? INT_W'(shifted) : '0;
      end else if (kind1_ff == KIND_AMBIENT) begin
         inten_in = INT_W'(scale1_ff);
      end else begin
         inten_in = ONE_INT;
      end
   end

   always_comb begin
      logic [MUL_W-1:0] p;
      for (int c = 0; c < 3; c++) begin
         p = MUL_W'(inten_ff) * MUL_W'(color2_ff[c]);
         con_in[c] = p[MUL_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue && slot_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      kind1_ff  <= slot.kind;
      scale1_ff <= slot.scale;
      color1_ff <= slot.color;
      inten_ff  <= inten_in;
      color2_ff <= color1_ff;
      con_ff    <= con_in;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff <= '0;
      end else if (v3_ff) begin
         for (int c = 0; c < 3; c++) begin
            sum_ff[c] <= sum_ff[c] + SUM_W'(con_ff[c]);
         end
      end
   end

   assign sum = sum_ff;

endmodule

@@ design/vertex_light_accumulator.sv @@
// Channel  | Direction | Handshake             | Payload
// req_     | in        | req_valid / req_ready | func, slot, light_type, color, vec, scale
// rsp_     | out       | rsp_valid / rsp_ready | light_r, light_g, light_b
//
// Write and clear items complete as they are accepted and leave req_ready high. A vertex
// item keeps req_ready low after it is accepted: the slot ring rotates once past the shade
// pipeline, one slot per cycle, then the four-stage pipeline drains. Its result is registered
// at the end of that pass, and no new item is taken until then. The result waits in
// an output register; a vertex item finishing while the previous result is still untaken
// holds there. Synchronous active-high reset empties all slots; no clearing pass is needed.
module vertex_light_accumulator import vla_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [KIND_W-1:0]   req_light_type,
   input  logic [COLOR_W-1:0]  req_color_r,
   input  logic [COLOR_W-1:0]  req_color_g,
   input  logic [COLOR_W-1:0]  req_color_b,
   input  logic [VEC_W-1:0]    req_vec_x,
   input  logic [VEC_W-1:0]    req_vec_y,
   input  logic [VEC_W-1:0]    req_vec_z,
   input  logic [COLOR_W-1:0]  req_ambient_scale,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_W-1:0]    rsp_light_r,
   output logic [OUT_W-1:0]    rsp_light_g,
   output logic [OUT_W-1:0]    rsp_light_b
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [CNT_W-1:0] CNT_ISSUE = CNT_W'(NUM_LIGHTS);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NUM_LIGHTS + PIPE_LAT - 1);
   localparam logic [SUM_W-1:0] SAT       = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [2:0][VEC_W-1:0]    normal_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0][OUT_W-1:0]    light_ff;

   logic                     accept, vertex_go, write_go, clear_go;
   logic                     issue, load;
   slot_type                 wr_data;
   cell_ctl_type             cell_ctl [NUM_LIGHTS];
   logic                     cell_valid [NUM_LIGHTS];
   slot_type                 cell_data [NUM_LIGHTS];
   logic [2:0][SUM_W-1:0]    sum;
   logic [2:0][OUT_W-1:0]    light_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign vertex_go = accept && (req_func == FUNC_VERTEX);
   assign clear_go  = accept && (req_func == FUNC_CLEAR);
   assign write_go  = accept && (req_func == FUNC_WRITE) && (32'(req_slot) < NUM_LIGHTS);

   assign issue = (state_ff == ST_RUN) && (cnt_ff < CNT_ISSUE);
   assign load  = (state_ff == ST_RUN) && (cnt_ff == CNT_LAST)
               && (!rsp_valid_ff || rsp_ready);

   assign wr_data.kind  = req_light_type;
   assign wr_data.color = {req_color_b, req_color_g, req_color_r};
   assign wr_data.dir   = {req_vec_z, req_vec_y, req_vec_x};
   assign wr_data.scale = req_ambient_scale;

   // Ring of slots: cell 0 feeds the shade pipeline, each cell takes its upper
   // neighbor, and a full rotation brings every slot back to its home cell.
   for (genvar i = 0; i < NUM_LIGHTS; i++) begin : g_cell
      localparam int NB = (i + 1) % NUM_LIGHTS;

      assign cell_ctl[i].shift = issue;
      assign cell_ctl[i].clear = clear_go;
      assign cell_ctl[i].write = write_go && (32'(req_slot) == i);

      vla_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl[i]),
         .wr_data  (wr_data),
         .nb_valid (cell_valid[NB]),
         .nb_data  (cell_data[NB]),
         .valid    (cell_valid[i]),
         .data     (cell_data[i])
      );
   end

   vla_shade u_shade (
      .clock      (clock),
      .reset      (reset),
      .start      (vertex_go),
      .issue      (issue),
      .slot_valid (cell_valid[0]),
      .slot       (cell_data[0]),
      .normal     (normal_ff),
      .sum        (sum)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (vertex_go) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (load) begin
               state_in = ST_IDLE;
            end else if (cnt_ff != CNT_LAST) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         light_in[c] = (sum[c] > SAT) ? SAT[OUT_W-1:0] : sum[c][OUT_W-1:0];
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vertex_go) begin
         normal_ff <= {req_vec_z, req_vec_y, req_vec_x};
      end
      if (load) begin
         light_ff <= light_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_light_r = light_ff[0];
   assign rsp_light_g = light_ff[1];
   assign rsp_light_b = light_ff[2];

endmodule

@@ design/vla_checker.sv @@
`include "vertex_light_accumulator_macros.svh"

module vla_checker import vla_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [FUNC_W-1:0]   req_func,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [OUT_W-1:0]    rsp_light_r,
   input logic [OUT_W-1:0]    rsp_light_g,
   input logic [OUT_W-1:0]    rsp_light_b
);

   // a vertex item keeps the block busy for at least the next cycle
   `VLA_ASSERT_NEXT(a_vertex_busy, req_valid && req_ready && req_func == FUNC_VERTEX,
                    !req_ready, "vertex item did not make the block busy")

   // a write or clear item leaves the block ready again
   `VLA_ASSERT_NEXT(a_cfg_item_done,
                    req_valid && req_ready && (req_func == FUNC_WRITE || req_func == FUNC_CLEAR),
                    req_ready, "write or clear item kept the block busy")

   // a new result only appears at the end of a vertex pass
   `VLA_ASSERT_NOW(a_rsp_after_pass, $rose(rsp_valid), !$past(req_ready),
                   "result appeared without a vertex pass")

   `VLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_light_r) && $stable(rsp_light_g)
                    && $stable(rsp_light_b), "stalled result changed")

endmodule

bind vertex_light_accumulator vla_checker u_checker (.*);
